>>> design/fqd_pkg.sv
// fqd_pkg: shared constants, codes and types for the queue with delete
// no dependencies; imported by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package fqd_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int CNT_OUT_W   = 5;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK_EMPTY    = 2'd0;
  localparam logic [ST_W-1:0] ST_OK_NONEMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FAIL        = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic              enq;    // write data at the tail slot
    logic              deq;    // every cell takes its neighbor's value
    logic              del;    // cells at or past the first match shift
    logic [DATA_W-1:0] data;   // enqueue value or search key
    logic [CNT_W-1:0]  count;  // entries held before this beat
  } fqd_ctrl_t;

endpackage

>>> design/fqd_if.sv
// fqd_if: valid/ready channel interfaces for command beats and result beats
// depends on fqd_pkg
`timescale 1ns / 1ps

interface fqd_in_if
  import fqd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] value_in;

  modport source (output valid, output opcode, output value_in, input ready);
  modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface fqd_out_if
  import fqd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [DATA_W-1:0]    value_out;
  logic [CNT_OUT_W-1:0] count_out;

  modport source (output valid, output status, output value_out, output count_out,
                  input ready);
  modport sink   (input valid, input status, input value_out, input count_out,
                  output ready);
endinterface

>>> design/fifo_queue_with_delete.sv
// fifo_queue_with_delete: bounded queue with enqueue, dequeue and delete by value
// result: registered from the accepted command beat and held in an output register
// throughput: one command beat per cycle while no result beat is stalled; all slots compare the key in parallel
// a stalled result beat holds off new command beats
// reset (rst_n, synchronous, active low) empties the queue and clears the result valid
// depends on fqd_pkg, fqd_if and fqd_cell
`timescale 1ns / 1ps

module fifo_queue_with_delete
  import fqd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  fqd_in_if.sink   in_chan,
  fqd_out_if.source out_chan
);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic [ST_W-1:0]      status_r;
  logic [ST_W-1:0]      status_nxt;
  logic [DATA_W-1:0]    vout_r;
  logic [DATA_W-1:0]    vout_nxt;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  logic                 accept;
  logic                 not_full;
  logic                 not_empty;
  logic                 found;
  fqd_ctrl_t            ctrl;
  logic [QUEUE_DEPTH:0] hit_chain;
  logic [DATA_W-1:0]    cell_val [QUEUE_DEPTH];

  // handshake
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign not_full  = count_r < DEPTH_CNT;
  assign not_empty = count_r != '0;
  assign found     = hit_chain[QUEUE_DEPTH];

  // command decode
  always_comb begin
    ctrl       = '0;
    ctrl.data  = in_chan.value_in;
    ctrl.count = count_r;
    status_nxt = ST_FAIL;
    vout_nxt   = '0;
    count_nxt  = count_r;
    unique case (in_chan.opcode)
      OP_ENQ: begin
        if (not_full) begin
          ctrl.enq   = accept;
          status_nxt = not_empty ? ST_OK_NONEMPTY : ST_OK_EMPTY;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (not_empty) begin
          ctrl.deq   = accept;
          status_nxt = ST_OK_EMPTY;
          vout_nxt   = cell_val[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_DEL: begin
        ctrl.del = accept;
        if (found) begin
          status_nxt = ST_OK_EMPTY;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_FAIL;
      end
    endcase
  end

  // chain of slots, oldest at index zero
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    fqd_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctrl     (ctrl),
      .next_val (nbr),
      .hit_in   (hit_chain[i]),
      .hit_out  (hit_chain[i+1]),
      .val      (cell_val[i])
    );
  end

  // fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      vout_r   <= vout_nxt;
    end
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_r};

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.value_out = vout_r;
  assign out_chan.count_out = cnt_ext[CNT_OUT_W-1:0];

`ifndef SYNTHESIS
  // fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("fill level above queue depth");

  // a stalled result beat freezes the queue
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> $stable(count_r))
    else $error("queue changed while result beat stalled");

  // a successful dequeue removes exactly one entry
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.opcode == OP_DEQ && not_empty |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("dequeue did not remove one entry");

  // a failed operation leaves the fill level as it was
  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_nxt == ST_FAIL |=> count_r == $past(count_r))
    else $error("failed operation changed the fill level");
`endif

endmodule

>>> design/fqd_cell.sv
// fqd_cell: one queue slot; compares against the key and shifts from its neighbor
// depends on fqd_pkg
`timescale 1ns / 1ps

module fqd_cell
  import fqd_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  fqd_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] next_val,
  input  logic              hit_in,
  output logic              hit_out,
  output logic [DATA_W-1:0] val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic [CNT_W:0]    idx_ext;
  logic              occupied;
  logic              at_tail;
  logic              hit;

  // slot position against the fill level
  assign idx_ext  = {{(CNT_W + 1 - IDX_W){1'b0}}, cell_idx};
  assign occupied = idx_ext < {1'b0, ctrl.count};
  assign at_tail  = idx_ext == {1'b0, ctrl.count};

  // match chain: any match at or before this slot
  assign hit     = occupied && (val_r == ctrl.data);
  assign hit_out = hit_in || hit;

  // next slot value
  always_comb begin
    val_nxt = val_r;
    if (ctrl.deq || (ctrl.del && hit_out)) begin
      val_nxt = next_val;
    end else if (ctrl.enq && at_tail) begin
      val_nxt = ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
